/* hdl/i2cm_pkg.sv */
// ---------------------------------------------------------------------------
// i2cm_pkg: shared types and constants of the i2c master
// item layouts, phase and command codes, fixed timing constants
// ---------------------------------------------------------------------------
`default_nettype none

package i2cm_pkg;

  localparam int DelayW   = 16;
  localparam int CountW   = 16;
  localparam int ByteW    = 8;
  localparam int BitCntW  = 4;
  localparam int CfgAddrW = 3;
  localparam int CfgDataW = 32;
  localparam int CfgIdxBit = 2;

  localparam logic [DelayW-1:0] HalfPeriodReset = 16'd5;
  localparam logic [7:0]        StartHoldTicks  = 8'd3;
  localparam logic [BitCntW-1:0] BitsPerByte    = 4'd8;
  localparam logic [ByteW-1:0]  ReadFill        = 8'hFF;

  // register index of half_period_ticks
  localparam logic REG_HALF_PERIOD = 1'b0;

  // command codes
  localparam logic [2:0] FUNC_BEGIN_WRITE  = 3'd0;
  localparam logic [2:0] FUNC_REQUEST_READ = 3'd1;
  localparam logic [2:0] FUNC_RESTART_READ = 3'd2;
  localparam logic [2:0] FUNC_WRITE_BYTE   = 3'd3;
  localparam logic [2:0] FUNC_READ_AUTO    = 3'd4;
  localparam logic [2:0] FUNC_READ_ACK     = 3'd5;
  localparam logic [2:0] FUNC_STOP         = 3'd6;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_START = 3'd1,
    PH_HI1   = 3'd2,
    PH_WAIT  = 3'd3,
    PH_HI2   = 3'd4,
    PH_STOPA = 3'd5,
    PH_STOPB = 3'd6
  } phase_t;

  typedef enum logic [1:0] {
    CTX_RESTART = 2'd0,
    CTX_BIT     = 2'd1,
    CTX_ACK     = 2'd2
  } ctx_t;

  typedef enum logic [1:0] {
    KIND_WRITE  = 2'd0,
    KIND_ADDR_W = 2'd1,
    KIND_ADDR_R = 2'd2,
    KIND_READ   = 2'd3
  } kind_t;

  typedef struct packed {
    logic              cmd_valid;
    logic [2:0]        func;
    logic [6:0]        slave_address;
    logic [ByteW-1:0]  write_byte;
    logic [CountW-1:0] read_count;
    logic              ack_flag;
    logic              scl_sense;
    logic              sda_sense;
  } i2cm_in_t;

  typedef struct packed {
    logic             scl_low;
    logic             sda_low;
    logic             busy_res;
    logic             done_res;
    logic [ByteW-1:0] read_data;
    logic             nack;
  } i2cm_out_t;

endpackage

`default_nettype wire

/* hdl/i2cm_cfg_regs.sv */
// ---------------------------------------------------------------------------
// i2cm_cfg_regs: configuration register bank
// apb-style write/read of the scl half period, a zero half period is used as one tick
// ---------------------------------------------------------------------------
`default_nettype none

module i2cm_cfg_regs
  import i2cm_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [CfgAddrW-1:0] paddr,
  input  wire logic [CfgDataW-1:0] pwdata,
  output logic      [CfgDataW-1:0] prdata,
  output logic                     pready,
  output logic      [DelayW-1:0]   half_ticks
);

  logic [DelayW-1:0] half_period_r;
  logic [DelayW-1:0] half_period_nxt;
  logic              wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr[CfgIdxBit] == REG_HALF_PERIOD);

  always_comb begin
    half_period_nxt = half_period_r;
    if (wr_en) begin
      half_period_nxt = pwdata[DelayW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_period_r <= HalfPeriodReset;
    end else begin
      half_period_r <= half_period_nxt;
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[CfgIdxBit] == REG_HALF_PERIOD) begin
      prdata = {{(CfgDataW-DelayW){1'b0}}, half_period_r};
    end
  end

  // a zero half period behaves as one tick
  assign half_ticks = (half_period_r == '0) ? {{(DelayW-1){1'b0}}, 1'b1} : half_period_r;

endmodule

`default_nettype wire

/* hdl/i2cm_core.sv */
// ---------------------------------------------------------------------------
// i2cm_core: bus sequencer of the i2c master
// phase state machine, delay counter, bit shifter and status; one step per item
// ---------------------------------------------------------------------------
`default_nettype none

module i2cm_core
  import i2cm_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              step_en,
  input  wire i2cm_in_t          in_item,
  input  wire logic [DelayW-1:0] half_ticks,
  output i2cm_out_t              res
);

  phase_t             phase_r, phase_nxt;
  logic [DelayW-1:0]  delay_count_r, delay_count_nxt;
  logic [BitCntW-1:0] bit_count_r, bit_count_nxt;
  logic [ByteW-1:0]   shift_byte_r, shift_byte_nxt;
  logic [CountW-1:0]  remaining_reads_r, remaining_reads_nxt;
  logic               address_status_r, address_status_nxt;
  logic               ack_pending_r, ack_pending_nxt;
  logic               scl_drive_r, scl_drive_nxt;
  logic               sda_drive_r, sda_drive_nxt;
  ctx_t               after_high_r, after_high_nxt;
  kind_t              xfer_kind_r, xfer_kind_nxt;
  logic [ByteW-1:0]   held_data_r, held_data_nxt;
  logic               held_nack_r, held_nack_nxt;

  logic               delay_run;
  logic [DelayW-1:0]  delay_dec;
  logic [ByteW-1:0]   shifted;
  logic [BitCntW-1:0] bit_inc;
  logic               done;

  assign delay_run = delay_count_r > {{(DelayW-1){1'b0}}, 1'b1};
  assign delay_dec = delay_count_r - {{(DelayW-1){1'b0}}, 1'b1};
  assign shifted   = {shift_byte_r[ByteW-2:0], in_item.sda_sense};
  assign bit_inc   = bit_count_r + {{(BitCntW-1){1'b0}}, 1'b1};

  // next state
  always_comb begin
    phase_nxt           = phase_r;
    delay_count_nxt     = delay_count_r;
    bit_count_nxt       = bit_count_r;
    shift_byte_nxt      = shift_byte_r;
    remaining_reads_nxt = remaining_reads_r;
    address_status_nxt  = address_status_r;
    ack_pending_nxt     = ack_pending_r;
    scl_drive_nxt       = scl_drive_r;
    sda_drive_nxt       = sda_drive_r;
    after_high_nxt      = after_high_r;
    xfer_kind_nxt       = xfer_kind_r;
    held_data_nxt       = held_data_r;
    held_nack_nxt       = held_nack_r;

    case (phase_r)
      PH_IDLE: begin
        if (in_item.cmd_valid) begin
          case (in_item.func)
            FUNC_BEGIN_WRITE: begin
              shift_byte_nxt  = {in_item.slave_address, 1'b0};
              xfer_kind_nxt   = KIND_ADDR_W;
              sda_drive_nxt   = 1'b1;
              phase_nxt       = PH_START;
              delay_count_nxt = {{(DelayW-8){1'b0}}, StartHoldTicks};
            end
            FUNC_REQUEST_READ: begin
              shift_byte_nxt      = {in_item.slave_address, 1'b1};
              xfer_kind_nxt       = KIND_ADDR_R;
              remaining_reads_nxt = in_item.read_count;
              sda_drive_nxt       = 1'b1;
              phase_nxt           = PH_START;
              delay_count_nxt     = {{(DelayW-8){1'b0}}, StartHoldTicks};
            end
            FUNC_RESTART_READ: begin
              shift_byte_nxt      = {in_item.slave_address, 1'b1};
              xfer_kind_nxt       = KIND_ADDR_R;
              remaining_reads_nxt = in_item.read_count;
              after_high_nxt      = CTX_RESTART;
              phase_nxt           = PH_HI1;
              delay_count_nxt     = half_ticks;
            end
            FUNC_WRITE_BYTE: begin
              shift_byte_nxt  = in_item.write_byte;
              xfer_kind_nxt   = KIND_WRITE;
              bit_count_nxt   = '0;
              sda_drive_nxt   = ~in_item.write_byte[ByteW-1];
              after_high_nxt  = CTX_BIT;
              phase_nxt       = PH_HI1;
              delay_count_nxt = half_ticks;
            end
            FUNC_READ_AUTO, FUNC_READ_ACK: begin
              if (in_item.func == FUNC_READ_AUTO) begin
                ack_pending_nxt     = remaining_reads_r > {{(CountW-1){1'b0}}, 1'b1};
                remaining_reads_nxt = remaining_reads_r - {{(CountW-1){1'b0}}, 1'b1};
              end else begin
                ack_pending_nxt = in_item.ack_flag;
              end
              shift_byte_nxt  = ReadFill;
              xfer_kind_nxt   = KIND_READ;
              bit_count_nxt   = '0;
              sda_drive_nxt   = ~ReadFill[ByteW-1];
              after_high_nxt  = CTX_BIT;
              phase_nxt       = PH_HI1;
              delay_count_nxt = half_ticks;
            end
            FUNC_STOP: begin
              sda_drive_nxt   = 1'b1;
              phase_nxt       = PH_STOPA;
              delay_count_nxt = half_ticks;
            end
            default: begin
            end
          endcase
        end
      end
      PH_START: begin
        if (delay_run) begin
          delay_count_nxt = delay_dec;
        end else begin
          scl_drive_nxt   = 1'b1;
          bit_count_nxt   = '0;
          sda_drive_nxt   = ~shift_byte_r[ByteW-1];
          after_high_nxt  = CTX_BIT;
          phase_nxt       = PH_HI1;
          delay_count_nxt = half_ticks;
        end
      end
      PH_HI1: begin
        if (delay_run) begin
          delay_count_nxt = delay_dec;
        end else begin
          scl_drive_nxt = 1'b0;
          phase_nxt     = PH_WAIT;
        end
      end
      PH_WAIT: begin
        // slave may stretch the clock
        if (in_item.scl_sense) begin
          phase_nxt       = PH_HI2;
          delay_count_nxt = half_ticks;
        end
      end
      PH_HI2: begin
        if (delay_run) begin
          delay_count_nxt = delay_dec;
        end else begin
          case (after_high_r)
            CTX_RESTART: begin
              sda_drive_nxt   = 1'b1;
              phase_nxt       = PH_START;
              delay_count_nxt = {{(DelayW-8){1'b0}}, StartHoldTicks};
            end
            CTX_BIT: begin
              scl_drive_nxt  = 1'b1;
              shift_byte_nxt = shifted;
              bit_count_nxt  = bit_inc;
              after_high_nxt = (bit_inc < BitsPerByte) ? CTX_BIT : CTX_ACK;
              phase_nxt       = PH_HI1;
              delay_count_nxt = half_ticks;
              if (bit_inc < BitsPerByte) begin
                sda_drive_nxt = ~shifted[ByteW-1];
              end else begin
                held_data_nxt = shifted;
                sda_drive_nxt = (xfer_kind_r == KIND_READ) && ack_pending_r;
              end
            end
            default: begin
              scl_drive_nxt = 1'b1;
              if (xfer_kind_r != KIND_READ) begin
                held_nack_nxt = in_item.sda_sense;
              end
              if (xfer_kind_r == KIND_ADDR_W) begin
                address_status_nxt = in_item.sda_sense;
              end
              phase_nxt = PH_IDLE;
            end
          endcase
        end
      end
      PH_STOPA: begin
        if (delay_run) begin
          delay_count_nxt = delay_dec;
        end else begin
          scl_drive_nxt   = 1'b0;
          phase_nxt       = PH_STOPB;
          delay_count_nxt = half_ticks;
        end
      end
      PH_STOPB: begin
        if (delay_run) begin
          delay_count_nxt = delay_dec;
        end else begin
          sda_drive_nxt = 1'b0;
          held_nack_nxt = address_status_r;
          phase_nxt     = PH_IDLE;
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    done = 1'b0;
    case (phase_r)
      PH_HI2:   done = !delay_run && (after_high_r == CTX_ACK);
      PH_STOPB: done = !delay_run;
      default:  done = 1'b0;
    endcase
    res.scl_low   = scl_drive_nxt;
    res.sda_low   = sda_drive_nxt;
    res.busy_res  = (phase_nxt != PH_IDLE);
    res.done_res  = done;
    res.read_data = held_data_nxt;
    res.nack      = held_nack_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r           <= PH_IDLE;
      delay_count_r     <= '0;
      bit_count_r       <= '0;
      shift_byte_r      <= '0;
      remaining_reads_r <= '0;
      address_status_r  <= 1'b0;
      ack_pending_r     <= 1'b0;
      scl_drive_r       <= 1'b0;
      sda_drive_r       <= 1'b0;
      after_high_r      <= CTX_RESTART;
      xfer_kind_r       <= KIND_WRITE;
      held_data_r       <= '0;
      held_nack_r       <= 1'b0;
    end else if (step_en) begin
      phase_r           <= phase_nxt;
      delay_count_r     <= delay_count_nxt;
      bit_count_r       <= bit_count_nxt;
      shift_byte_r      <= shift_byte_nxt;
      remaining_reads_r <= remaining_reads_nxt;
      address_status_r  <= address_status_nxt;
      ack_pending_r     <= ack_pending_nxt;
      scl_drive_r       <= scl_drive_nxt;
      sda_drive_r       <= sda_drive_nxt;
      after_high_r      <= after_high_nxt;
      xfer_kind_r       <= xfer_kind_nxt;
      held_data_r       <= held_data_nxt;
      held_nack_r       <= held_nack_nxt;
    end
  end

  // timed phases always hold a loaded, nonzero delay
  a_delay_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_START || phase_r == PH_HI1 || phase_r == PH_HI2 ||
     phase_r == PH_STOPA || phase_r == PH_STOPB) |-> (delay_count_r != '0))
    else $error("timed phase with zero delay count");

  a_bit_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    bit_count_r <= BitsPerByte)
    else $error("bit counter past one byte");

  // scl must be released while waiting out clock stretching
  a_wait_released: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_WAIT) |-> !scl_drive_r)
    else $error("scl held low while waiting for slave");

  a_start_sda_low: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_START) |-> sda_drive_r)
    else $error("start condition without sda pulled low");

endmodule

`default_nettype wire

/* hdl/i2c_master_bit_level_controller.sv */
// ---------------------------------------------------------------------------
// i2c_master_bit_level_controller: tick-level open-drain i2c master
// one input item per clock tick while in_stall is low, one result item per input item
// ---------------------------------------------------------------------------
//
//  channel | ports                               | moves
//  --------+-------------------------------------+-----------------------------------
//  in      | in_valid, in_stall, in_data         | one tick: command + sensed lines
//  out     | out_valid, out_stall, out_data      | line drives, busy, done, data, nack
//  cfg     | psel, penable, pwrite, paddr, ...   | half_period_ticks at byte addr 0
//
//  the sequencer steps once per accepted item and the result lands in the output
//    register at the same edge
//  a new item is accepted every cycle while the output register is empty or drained
//  out_stall holds the result; input stalls only while a result waits under stall
//  rst_n is synchronous: sequencer idle, lines released, half period back to 5
//
`default_nettype none

module i2c_master_bit_level_controller
  import i2cm_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  // input items
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire i2cm_in_t            in_data,
  // result items
  output logic                     out_valid,
  input  wire logic                out_stall,
  output i2cm_out_t                out_data,
  // configuration
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [CfgAddrW-1:0] paddr,
  input  wire logic [CfgDataW-1:0] pwdata,
  output logic      [CfgDataW-1:0] prdata,
  output logic                     pready
);

  logic              step_en;
  logic [DelayW-1:0] half_ticks;
  i2cm_out_t         res;
  logic              out_valid_r, out_valid_nxt;
  i2cm_out_t         out_data_r;

  // output register parts the two sides; accept whenever it can take a new result
  assign in_stall = out_valid_r && out_stall;
  assign step_en  = in_valid && !in_stall;

  i2cm_cfg_regs u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .half_ticks (half_ticks)
  );

  // sequencer: state registers and one step of next-state logic
  i2cm_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .step_en    (step_en),
    .in_item    (in_data),
    .half_ticks (half_ticks),
    .res        (res)
  );

  // result register valid: set by a step, cleared when taken with nothing new
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (step_en) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload of the result register, loaded only with a step
  always_ff @(posedge clk) begin
    if (step_en) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire
